### rtl/mfpo_pkg.sv
`timescale 1ns / 1ps

package mfpo_pkg;

  // Default geometry of the panel.
  localparam int BYTES_PER_ROW_DEF = 25;
  localparam int ROWS_DEF          = 96;
  localparam int WIDTH_PIXELS_DEF  = 200;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // Command field widths, sized for the largest geometry the block supports.
  localparam int CMD_ADDR_W = 19;
  localparam int CMD_ROW_W  = 11;

  // Function codes of the input word. The last two are unassigned.
  typedef enum logic [2:0] {
    FN_SET_PIXEL,
    FN_CLEAR_PIXEL,
    FN_INVERT_RECT,
    FN_FILL,
    FN_INVERT_ALL,
    FN_READ_BYTE,
    FN_SPARE6,
    FN_SPARE7
  } func_t;

  // Status codes of the output word.
  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  // What the back end does to each byte it walks over.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SET,
    ACT_CLR,
    ACT_FLIP,
    ACT_FILL,
    ACT_READ
  } act_t;

  // One classified operation: a walk over nrows rows of ncols+1 bytes each.
  typedef struct packed {
    act_t                  act;
    logic                  status;
    logic                  fill;
    logic [CMD_ADDR_W-1:0] start;
    logic [7:0]            ncols;
    logic [CMD_ROW_W-1:0]  nrows;
    logic [7:0]            lmask;
    logic [7:0]            rmask;
  } cmd_t;

endpackage

### rtl/mfpo_ram.sv
`timescale 1ns / 1ps

module mfpo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/mfpo_front.sv
`timescale 1ns / 1ps

module mfpo_front import mfpo_pkg::*; #(
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROWS          = ROWS_DEF,
  parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  x,
  input  logic [6:0]  y,
  input  logic [7:0]  width,
  input  logic [6:0]  height,
  input  logic        fill_ones,
  input  logic [11:0] address,
  input  logic        busy,
  input  logic        queue_full,
  output logic        push,
  output cmd_t        cmd
);

  localparam int FRAME_BYTES = BYTES_PER_ROW * ROWS;
  localparam logic [11:0]           WIDTH_LIM = 12'(WIDTH_PIXELS);
  localparam logic [10:0]           ROW_LIM   = 11'(ROWS);
  localparam logic [CMD_ADDR_W-1:0] FRAME_LIM = CMD_ADDR_W'(FRAME_BYTES);
  localparam logic [7:0]            NCOLS_ALL = 8'(BYTES_PER_ROW - 1);

  logic [8:0]            x_end;
  logic [8:0]            x_last;
  logic [7:0]            y_end;
  logic                  px_bad;
  logic                  rect_bad;
  logic                  rect_empty;
  logic                  rd_bad;
  logic [CMD_ADDR_W-1:0] pixel_addr;

  assign x_end  = {1'b0, x} + {1'b0, width};
  assign x_last = x_end - 9'd1;
  assign y_end  = {1'b0, y} + {1'b0, height};

  assign px_bad     = ({4'b0, x} >= WIDTH_LIM) || ({4'b0, y} >= ROW_LIM);
  assign rect_bad   = ({3'b0, x_end} > WIDTH_LIM) || ({3'b0, y_end} > ROW_LIM);
  assign rect_empty = (width == 8'd0) || (height == 7'd0);
  assign rd_bad     = CMD_ADDR_W'(address) >= FRAME_LIM;

  // Byte that holds the left edge pixel: row start plus column byte.
  assign pixel_addr = CMD_ADDR_W'(y) * CMD_ADDR_W'(BYTES_PER_ROW) + CMD_ADDR_W'(x[7:3]);

  always_comb begin
    cmd.act    = ACT_NONE;
    cmd.status = ST_DONE;
    cmd.fill   = fill_ones;
    cmd.start  = pixel_addr;
    cmd.ncols  = 8'd0;
    cmd.nrows  = CMD_ROW_W'(1);
    cmd.lmask  = 8'h80 >> x[2:0];
    cmd.rmask  = 8'hFF;
    case (func)
      FN_SET_PIXEL: begin
        if (px_bad) begin
          cmd.status = ST_REJECTED;
        end else begin
          cmd.act = ACT_SET;
        end
      end
      FN_CLEAR_PIXEL: begin
        if (px_bad) begin
          cmd.status = ST_REJECTED;
        end else begin
          cmd.act = ACT_CLR;
        end
      end
      FN_INVERT_RECT: begin
        if (rect_bad) begin
          cmd.status = ST_REJECTED;
        end else if (!rect_empty) begin
          cmd.act   = ACT_FLIP;
          cmd.ncols = {2'b00, x_last[8:3]} - {3'b000, x[7:3]};
          cmd.nrows = CMD_ROW_W'(height);
          cmd.lmask = 8'hFF >> x[2:0];
          cmd.rmask = 8'hFF << (3'd7 - x_last[2:0]);
        end
      end
      FN_FILL: begin
        cmd.act   = ACT_FILL;
        cmd.start = '0;
        cmd.ncols = NCOLS_ALL;
        cmd.nrows = CMD_ROW_W'(ROWS);
        cmd.lmask = 8'hFF;
      end
      FN_INVERT_ALL: begin
        cmd.act   = ACT_FLIP;
        cmd.start = '0;
        cmd.ncols = NCOLS_ALL;
        cmd.nrows = CMD_ROW_W'(ROWS);
        cmd.lmask = 8'hFF;
      end
      FN_READ_BYTE: begin
        cmd.start = CMD_ADDR_W'(address);
        if (rd_bad) begin
          cmd.status = ST_REJECTED;
        end else begin
          cmd.act = ACT_READ;
        end
      end
      default: begin
        cmd.status = ST_REJECTED;
      end
    endcase
  end

  assign in_stall = busy || queue_full;
  assign push     = in_valid && !in_stall;

endmodule

### rtl/mfpo_cmd_fifo.sv
`timescale 1ns / 1ps

module mfpo_cmd_fifo import mfpo_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        store[wr_ptr] <= push_cmd;
        wr_ptr        <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/mfpo_back.sv
`timescale 1ns / 1ps

module mfpo_back import mfpo_pkg::*; #(
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROWS          = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       status,
  output logic [7:0] read_data
);

  localparam int FRAME_BYTES = BYTES_PER_ROW * ROWS;
  localparam int RAM_AW      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [CMD_ADDR_W-1:0] FRAME_LIM = CMD_ADDR_W'(FRAME_BYTES);
  localparam logic [CMD_ADDR_W-1:0] ROW_STEP  = CMD_ADDR_W'(BYTES_PER_ROW);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                state;
  logic                  clearing;
  logic [CMD_ADDR_W-1:0] cur_addr;
  logic [CMD_ADDR_W-1:0] row_addr;
  logic [7:0]            col_idx;
  logic [7:0]            ncols;
  logic [CMD_ROW_W-1:0]  rows_left;
  logic [7:0]            lmask;
  logic [7:0]            rmask;
  act_t                  act;
  logic                  fill;

  // Writeback stage, which writes each byte in the cycle after its read.
  logic                  wb_valid;
  logic                  wb_last;
  logic                  wb_we;
  logic [RAM_AW-1:0]     wb_addr;
  logic [7:0]            wb_mask;
  act_t                  wb_act;
  logic                  wb_fill;
  logic                  fwd;
  logic [7:0]            fwd_data;

  logic                  out_valid_q;
  logic                  status_q;
  logic [7:0]            read_data_q;

  logic                  out_free;
  logic                  last_byte;
  logic                  in_frame;
  logic                  issue;
  logic                  rd_en;
  logic [7:0]            byte_mask;
  logic [7:0]            ram_rdata;
  logic [7:0]            old_byte;
  logic [7:0]            new_byte;
  logic                  wb_report;
  logic                  load_done;
  logic                  out_load;

  assign out_free  = !out_valid_q || !out_stall;
  assign last_byte = (col_idx == ncols) && (rows_left == CMD_ROW_W'(1));
  assign in_frame  = cur_addr < FRAME_LIM;
  // The last byte is read only once the result slot will be free for it; the clearing pass does not wait.
  assign issue     = (state == S_WALK) && (!last_byte || clearing || out_free);
  assign rd_en     = issue && in_frame;
  assign byte_mask = ((col_idx == 8'd0) ? lmask : 8'hFF) & ((col_idx == ncols) ? rmask : 8'hFF);

  assign old_byte = fwd ? fwd_data : ram_rdata;

  always_comb begin
    case (wb_act)
      ACT_SET:  new_byte = old_byte | wb_mask;
      ACT_CLR:  new_byte = old_byte & ~wb_mask;
      ACT_FLIP: new_byte = old_byte ^ wb_mask;
      ACT_FILL: new_byte = wb_fill ? 8'hFF : 8'h00;
      default:  new_byte = old_byte;
    endcase
  end

  assign wb_report = wb_valid && wb_last && !clearing;
  assign pop       = (state == S_IDLE) && !empty &&
                     ((head.act != ACT_NONE) || (out_free && !wb_report));
  assign load_done = pop && (head.act == ACT_NONE);
  assign out_load  = wb_report || load_done;

  mfpo_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wb_valid && wb_we),
    .waddr (wb_addr),
    .wdata (new_byte),
    .re    (rd_en),
    .raddr (cur_addr[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // Reset starts a zero fill of the whole store.
      state       <= S_WALK;
      clearing    <= 1'b1;
      cur_addr    <= '0;
      row_addr    <= '0;
      col_idx     <= 8'd0;
      ncols       <= 8'(BYTES_PER_ROW - 1);
      rows_left   <= CMD_ROW_W'(ROWS);
      lmask       <= 8'hFF;
      rmask       <= 8'hFF;
      act         <= ACT_FILL;
      fill        <= 1'b0;
      wb_valid    <= 1'b0;
      fwd         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wb_valid <= issue;
      if (issue) begin
        wb_last  <= last_byte;
        wb_we    <= in_frame && (act != ACT_READ);
        wb_addr  <= cur_addr[RAM_AW-1:0];
        wb_mask  <= byte_mask;
        wb_act   <= act;
        wb_fill  <= fill;
        // The byte being written now would be missed by this read.
        fwd      <= wb_valid && wb_we && in_frame && (wb_addr == cur_addr[RAM_AW-1:0]);
        fwd_data <= new_byte;
      end

      if (wb_valid && wb_last && clearing) begin
        clearing <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (pop && (head.act != ACT_NONE)) begin
            cur_addr  <= head.start;
            row_addr  <= head.start;
            col_idx   <= 8'd0;
            ncols     <= head.ncols;
            rows_left <= head.nrows;
            lmask     <= head.lmask;
            rmask     <= head.rmask;
            act       <= head.act;
            fill      <= head.fill;
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          if (issue) begin
            if (last_byte) begin
              state <= S_IDLE;
            end else if (col_idx == ncols) begin
              col_idx   <= 8'd0;
              rows_left <= rows_left - CMD_ROW_W'(1);
              row_addr  <= row_addr + ROW_STEP;
              cur_addr  <= row_addr + ROW_STEP;
            end else begin
              col_idx  <= col_idx + 8'd1;
              cur_addr <= cur_addr + CMD_ADDR_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
        status_q    <= load_done ? head.status : ST_DONE;
        read_data_q <= (wb_report && (wb_act == ACT_READ)) ? old_byte : 8'h00;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign busy      = clearing;
  assign out_valid = out_valid_q;
  assign status    = status_q;
  assign read_data = read_data_q;

endmodule

### rtl/mono_framebuffer_pixel_ops.sv
`timescale 1ns / 1ps

// One-bit framebuffer of ROWS rows by BYTES_PER_ROW bytes, leftmost pixel in
// the most significant bit, with pixel set and clear, rectangle invert, fill,
// whole-screen invert and byte readback; every input word yields exactly one
// output word carrying a status (1 for rejected coordinates or an unknown
// function) and the byte read, which is zero for everything but a read. The
// front end classifies each word into a byte walk and queues it; the back end
// runs the walk against a single frame RAM with one read and one write port,
// reading each byte and writing it back in the following cycle, so the RAM
// port is what sets the pace and a walk lasts longer the more bytes it
// covers; a rejected or empty operation walks no bytes. After reset the back
// end zero-fills the RAM, holding in_stall high throughout. The output word
// sits in a register, so a stalled consumer does not stop the front end from
// queueing further words.

module mono_framebuffer_pixel_ops import mfpo_pkg::*; #(
  parameter int BYTES_PER_ROW = BYTES_PER_ROW_DEF,
  parameter int ROWS          = ROWS_DEF,
  parameter int WIDTH_PIXELS  = WIDTH_PIXELS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [7:0]  x,
  input  logic [6:0]  y,
  input  logic [7:0]  width,
  input  logic [6:0]  height,
  input  logic        fill_ones,
  input  logic [11:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [7:0]  read_data
);

  // Classified command handed from the front end through the queue.
  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  logic busy;

  mfpo_front #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .ROWS          (ROWS),
    .WIDTH_PIXELS  (WIDTH_PIXELS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .x          (x),
    .y          (y),
    .width      (width),
    .height     (height),
    .fill_ones  (fill_ones),
    .address    (address),
    .busy       (busy),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  mfpo_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (queue_empty)
  );

  // The back end owns the frame RAM and the output register.
  mfpo_back #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .ROWS          (ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (queue_empty),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_data (read_data)
  );

endmodule

### rtl/mfpo_checker.sv
`timescale 1ns / 1ps

module mfpo_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       status,
  input logic [7:0] read_data
);

  // A held output word stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(read_data))
    else $error("output word changed while stalled");

  // A rejected word never carries data.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == 8'h00)
    else $error("rejected word with nonzero data");

  // The clearing pass holds off input right after reset.
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input taken during the clearing pass");

  // Nothing comes out in the first cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("output word right after reset");

endmodule

bind mono_framebuffer_pixel_ops mfpo_checker u_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench top level for the monochrome framebuffer block.
//
// The block keeps a 200 x 96 one-bit screen, 25 bytes per row, with the
// leftmost pixel of each byte in its most significant bit. Every input word
// carries one operation and yields exactly one output word, in order. The
// testbench holds its own copy of the screen. When a word is accepted, the
// driver applies the operation to that copy and queues the reply it must
// produce. The monitor pops the oldest queued reply for every reply the
// block hands over, and compares it field by field.

module tb_top;
  import mfpo_pkg::*;

  // Screen geometry follows the block's default parameters.
  localparam int ROW_BYTES    = BYTES_PER_ROW_DEF;
  localparam int SCREEN_ROWS  = ROWS_DEF;
  localparam int SCREEN_COLS  = WIDTH_PIXELS_DEF;
  localparam int SCREEN_BYTES = ROW_BYTES * SCREEN_ROWS;

  // A fill or a whole-screen invert walks every byte, and so does the
  // zero-fill after reset. The idle limit leaves a wide margin over both.
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 50;
  localparam int RANDOM_WORDS = 1125;
  localparam int PRINT_CAP = 40;

  // One input word, plus a flag that makes the driver wait until every
  // reply has come back before it offers this word.
  typedef struct {
    logic [2:0]  func;
    logic [7:0]  x;
    logic [6:0]  y;
    logic [7:0]  width;
    logic [6:0]  height;
    logic        fill_ones;
    logic [11:0] address;
    bit          drain_first;
  } pixel_word_t;

  typedef struct {
    logic       status;
    logic [7:0] read_data;
  } pixel_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [7:0]  x = '0;
  logic [6:0]  y = '0;
  logic [7:0]  width = '0;
  logic [6:0]  height = '0;
  logic        fill_ones = 1'b0;
  logic [11:0] address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;
  logic [7:0]  read_data;

  // The testbench's copy of the screen, blank after reset.
  logic [7:0] screen_copy [SCREEN_BYTES];

  pixel_word_t  pending_words [$];
  pixel_reply_t expected_replies [$];

  int mismatch_count = 0;
  int reply_count = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  mono_framebuffer_pixel_ops i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .x         (x),
    .y         (y),
    .width     (width),
    .height    (height),
    .fill_ones (fill_ones),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .read_data (read_data)
  );

  // Applies one word to the screen copy and returns the reply the block must
  // give for it. Pixel (col, row) sits in byte row*25 + col/8 at bit 7-col%8.
  function automatic pixel_reply_t apply_screen_op(pixel_word_t w);
    pixel_reply_t r;
    int col;
    int row;
    int idx;
    r.status = ST_DONE;
    r.read_data = 8'h00;
    case (w.func)
      FN_SET_PIXEL, FN_CLEAR_PIXEL: begin
        if (int'(w.x) >= SCREEN_COLS || int'(w.y) >= SCREEN_ROWS) begin
          r.status = ST_REJECTED;
        end else begin
          idx = int'(w.y) * ROW_BYTES + int'(w.x) / 8;
          if (w.func == FN_SET_PIXEL)
            screen_copy[idx] = screen_copy[idx] | (8'h80 >> w.x[2:0]);
          else
            screen_copy[idx] = screen_copy[idx] & ~(8'h80 >> w.x[2:0]);
        end
      end
      FN_INVERT_RECT: begin
        // The whole rectangle must fit; an empty one that fits is still done.
        if (int'(w.x) + int'(w.width) > SCREEN_COLS ||
            int'(w.y) + int'(w.height) > SCREEN_ROWS) begin
          r.status = ST_REJECTED;
        end else begin
          for (row = int'(w.y); row < int'(w.y) + int'(w.height); row++) begin
            for (col = int'(w.x); col < int'(w.x) + int'(w.width); col++) begin
              idx = row * ROW_BYTES + col / 8;
              screen_copy[idx] = screen_copy[idx] ^ (8'h80 >> (col % 8));
            end
          end
        end
      end
      FN_FILL: begin
        foreach (screen_copy[i]) screen_copy[i] = w.fill_ones ? 8'hFF : 8'h00;
      end
      FN_INVERT_ALL: begin
        foreach (screen_copy[i]) screen_copy[i] = ~screen_copy[i];
      end
      FN_READ_BYTE: begin
        if (int'(w.address) >= SCREEN_BYTES) r.status = ST_REJECTED;
        else r.read_data = screen_copy[w.address];
      end
      default: begin
        r.status = ST_REJECTED;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] reply %0d: %s: got %0d, expected %0d",
               $realtime, reply_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_word(input logic [2:0] f, input int px, input int py, input int pw,
                          input int ph, input logic ones, input int addr,
                          input bit drain = 1'b0);
    pixel_word_t w;
    w.func = f;
    w.x = px[7:0];
    w.y = py[6:0];
    w.width = pw[7:0];
    w.height = ph[6:0];
    w.fill_ones = ones;
    w.address = addr[11:0];
    w.drain_first = drain;
    pending_words.push_back(w);
  endtask

  // Driver. The sender works in bursts of random length separated by random
  // gaps; a word flagged to drain first is held back until the reply queue
  // is empty. A word stays on the port unchanged until it is accepted.
  pixel_word_t offered_word;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_words
    logic next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_screen_op(offered_word));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain_first || expected_replies.size() == 0)) begin
          offered_word = pending_words.pop_front();
          func      <= offered_word.func;
          x         <= offered_word.x;
          y         <= offered_word.y;
          width     <= offered_word.width;
          height    <= offered_word.height;
          fill_ones <= offered_word.fill_ones;
          address   <= offered_word.address;
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor. The receiver switches between its own stall modes: never
  // stalling, stalling now and then, stalling most of the time, and a
  // regular on/off pattern. Each accepted reply is checked against the
  // oldest expectation.
  int stall_mode = 0;
  int stall_run = 0;
  int stall_period = 2;
  int stall_phase = 0;

  always @(posedge clk) begin : check_replies
    pixel_reply_t want;
    logic next_stall;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with no word outstanding", int'(status), -1);
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch("status", int'(status), int'(want.status));
          if (read_data !== want.read_data)
            report_mismatch("read_data", int'(read_data), int'(want.read_data));
        end
        reply_count++;
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(16, 400);
        stall_period = $urandom_range(2, 5);
        stall_phase = 0;
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        default: begin
          next_stall = (stall_phase == 0);
          stall_phase = (stall_phase + 1) % stall_period;
        end
      endcase
      out_stall <= next_stall;
    end
  end

  // Watchdog: the run is stuck if neither side accepts anything for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    int px;
    int py;
    int pw;
    int ph;
    int last_x;
    int last_y;
    int total_words;
    foreach (screen_copy[i]) screen_copy[i] = 8'h00;
    last_x = 0;
    last_y = 0;

    // Directed words: corner pixels, every rejection, rectangle edges inside
    // bytes, empty rectangles, the full-screen rectangle, both fills, the
    // whole-screen invert, read limits and the unassigned functions.
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, 0);
    add_word(FN_SET_PIXEL,   0,   0,   255, 127, 1'b1, 4095);
    add_word(FN_SET_PIXEL,   199, 95,  0,   0,   1'b0, 0);
    add_word(FN_READ_BYTE,   255, 127, 255, 127, 1'b1, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, SCREEN_BYTES - 1);
    add_word(FN_CLEAR_PIXEL, 0,   0,   0,   0,   1'b0, 0);
    add_word(FN_SET_PIXEL,   200, 0,   0,   0,   1'b0, 0);
    add_word(FN_CLEAR_PIXEL, 255, 127, 0,   0,   1'b0, 0);
    add_word(FN_SET_PIXEL,   0,   96,  0,   0,   1'b0, 0);
    add_word(FN_INVERT_RECT, 3,   2,   13,  3,   1'b0, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, 2 * ROW_BYTES + 1);
    add_word(FN_INVERT_RECT, 0,   0,   200, 96,  1'b0, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, 2 * ROW_BYTES);
    add_word(FN_INVERT_RECT, 199, 0,   2,   1,   1'b0, 0);
    add_word(FN_INVERT_RECT, 0,   95,  1,   2,   1'b0, 0);
    add_word(FN_INVERT_RECT, 10,  10,  0,   5,   1'b0, 0);
    add_word(FN_INVERT_RECT, 10,  10,  7,   0,   1'b0, 0);
    add_word(FN_INVERT_RECT, 255, 127, 255, 127, 1'b1, 4095);
    add_word(FN_FILL,        0,   0,   0,   0,   1'b1, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, 1234);
    add_word(FN_INVERT_ALL,  0,   0,   0,   0,   1'b0, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, SCREEN_BYTES - 1, 1'b1);
    add_word(FN_FILL,        0,   0,   0,   0,   1'b0, 0);
    add_word(FN_READ_BYTE,   0,   0,   0,   0,   1'b0, SCREEN_BYTES);
    add_word(FN_SPARE6,      0,   0,   0,   0,   1'b0, 0);
    add_word(FN_SPARE7,      255, 127, 255, 127, 1'b1, 4095);

    // Random words. Most are legal pixel writes, reads and small rectangles,
    // with reads often aimed at the byte just written; the rest are screen
    // walks, rejected coordinates and unassigned functions.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 127);
      pw = $urandom_range(0, 255);
      ph = $urandom_range(0, 127);
      if (pick < 30) begin
        px = $urandom_range(0, SCREEN_COLS - 1);
        py = $urandom_range(0, SCREEN_ROWS - 1);
        last_x = px;
        last_y = py;
        add_word($urandom_range(0, 1) ? FN_SET_PIXEL : FN_CLEAR_PIXEL, px, py, pw, ph,
                 1'($urandom_range(0, 1)), $urandom_range(0, 4095));
      end else if (pick < 60) begin
        add_word(FN_READ_BYTE, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 1) ? last_y * ROW_BYTES + last_x / 8
                                      : $urandom_range(0, SCREEN_BYTES - 1),
                 (n % 200) == 199);
      end else if (pick < 75) begin
        px = $urandom_range(0, SCREEN_COLS - 1);
        py = $urandom_range(0, SCREEN_ROWS - 1);
        if ($urandom_range(0, 9) == 0) begin
          pw = $urandom_range(0, SCREEN_COLS - px);
          ph = $urandom_range(0, SCREEN_ROWS - py);
        end else begin
          pw = $urandom_range(0, (SCREEN_COLS - px < 24) ? SCREEN_COLS - px : 24);
          ph = $urandom_range(0, (SCREEN_ROWS - py < 6) ? SCREEN_ROWS - py : 6);
        end
        last_x = px;
        last_y = py;
        add_word(FN_INVERT_RECT, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 4095));
      end else if (pick < 80) begin
        add_word(FN_INVERT_RECT, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 4095));
      end else if (pick < 82) begin
        add_word(FN_FILL, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 4095));
      end else if (pick < 83) begin
        add_word(FN_INVERT_ALL, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 4095));
      end else if (pick < 90) begin
        add_word($urandom_range(0, 1) ? FN_SET_PIXEL : FN_CLEAR_PIXEL, px, py, pw, ph,
                 1'($urandom_range(0, 1)), $urandom_range(0, 4095));
      end else if (pick < 95) begin
        add_word(FN_READ_BYTE, px, py, pw, ph, 1'($urandom_range(0, 1)),
                 $urandom_range(0, 4095));
      end else begin
        add_word($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7, px, py, pw, ph,
                 1'($urandom_range(0, 1)), $urandom_range(0, 4095));
      end
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait until every word has had its reply, then give the block a short
    // tail in which a stray reply would show up.
    @(posedge clk);
    while (reply_count < total_words || pending_words.size() > 0 || in_valid ||
           expected_replies.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### mono_framebuffer_pixel_ops.f
rtl/mfpo_pkg.sv
rtl/mfpo_ram.sv
rtl/mfpo_front.sv
rtl/mfpo_cmd_fifo.sv
rtl/mfpo_back.sv
rtl/mono_framebuffer_pixel_ops.sv
rtl/mfpo_checker.sv
verif/tb_top.sv
